[src/pwa_pkg.sv]
`default_nettype none

package pwa_pkg;

    // Field widths
    localparam int W_DIST     = 16;
    localparam int W_DT       = 10;
    localparam int W_GAIN     = 24;
    localparam int W_TOL      = 16;
    localparam int W_TMO      = 16;
    localparam int W_PULSE    = 11;
    localparam int W_STATUS   = 2;
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 24;

    // Internal datapath widths
    localparam int W_ERR   = 17;  // right minus left, signed Q8.8
    localparam int W_PREV  = 18;
    localparam int W_INTEG = 48;
    localparam int W_MUL_A = 32;
    localparam int W_MUL_B = 24;
    localparam int W_PROD  = W_MUL_A + W_MUL_B;
    localparam int W_DIVN  = 72;  // dividend, a multiple of the radix step
    localparam int W_DIVD  = 10;  // divisor
    localparam int W_DCNT  = 5;
    localparam int W_QUOT  = 51;  // quotient magnitude, capped at 2^50
    localparam int W_ACC   = 54;

    localparam int DIV_BITS_PER_STEP = 4;
    localparam logic [W_DCNT-1:0] DIV_STEPS_I = W_DCNT'(18);  // 72-bit dividend
    localparam logic [W_DCNT-1:0] DIV_STEPS_D = W_DCNT'(13);  // 52-bit dividend
    localparam int D_ALIGN_SHIFT = 20;

    localparam logic [W_PULSE-1:0] STOP_PULSE = W_PULSE'(1500);
    localparam logic [7:0]         TURN_LIMIT = 8'd255;
    localparam logic [W_DIVD-1:0]  MS_PER_S   = W_DIVD'(1000);
    localparam logic [W_QUOT-1:0]  TERM_CAP   = {1'b1, {(W_QUOT-1){1'b0}}};

    // Configuration register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_SENSOR_SEL = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_PROP  = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_INTEG = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_GAIN_DERIV = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_ALIGN_TOL  = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_TIMEOUT    = 3'd5;

    // Configuration reset values
    localparam logic [W_GAIN-1:0] RST_GAIN_PROP  = W_GAIN'(131072);
    localparam logic [W_GAIN-1:0] RST_GAIN_INTEG = W_GAIN'(655);
    localparam logic [W_GAIN-1:0] RST_GAIN_DERIV = W_GAIN'(66);
    localparam logic [W_TOL-1:0]  RST_ALIGN_TOL  = W_TOL'(256);
    localparam logic [W_TMO-1:0]  RST_TIMEOUT    = W_TMO'(5000);

    typedef enum logic [W_STATUS-1:0] {
        ST_IDLE    = 2'd0,
        ST_RUN     = 2'd1,
        ST_ALIGNED = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef struct packed {
        logic              sensor_sel;
        logic [W_GAIN-1:0] gain_prop;
        logic [W_GAIN-1:0] gain_integ;
        logic [W_GAIN-1:0] gain_deriv;
        logic [W_TOL-1:0]  align_tol;
        logic [W_TMO-1:0]  timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [W_DIVN-1:0] dividend;
        logic [W_DIVD-1:0] divisor;
        logic [W_DCNT-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [W_QUOT-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[src/pwa_in_if.sv]
`default_nettype none

interface pwa_in_if import pwa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [W_DIST-1:0] left_long;
    logic [W_DIST-1:0] right_long;
    logic [W_DIST-1:0] left_short;
    logic [W_DIST-1:0] right_short;
    logic [W_DT-1:0]   interval_ms;

    modport source (
        output valid, op, left_long, right_long, left_short, right_short, interval_ms,
        input  ready
    );
    modport sink (
        input  valid, op, left_long, right_long, left_short, right_short, interval_ms,
        output ready
    );
endinterface

`default_nettype wire

[src/pwa_out_if.sv]
`default_nettype none

interface pwa_out_if import pwa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [W_PULSE-1:0]  left_pulse;
    logic [W_PULSE-1:0]  right_pulse;
    logic [W_STATUS-1:0] status;
    logic                zero_heading;

    modport source (
        output valid, left_pulse, right_pulse, status, zero_heading,
        input  ready
    );
    modport sink (
        input  valid, left_pulse, right_pulse, status, zero_heading,
        output ready
    );
endinterface

`default_nettype wire

[src/pid_wall_alignment_unit.sv]
`default_nettype none

// Wall alignment PID controller. A start item (op 0) opens a run and answers
// with stop pulses and status running; a sample item (op 1) advances the run:
// it adds its interval to the elapsed time, ends the run as timed out at the
// limit, ends it as aligned (with zero_heading raised) when the selected
// sensor pair differs by less than the tolerance, and otherwise answers with
// 1500 plus a PID turn clamped to +-255 on both sides. Each input item gives
// exactly one result item. The block takes one item at a time: a start item,
// a sample outside a run, a timeout or an alignment goes from the accept
// through the check step to the output step; a sample that runs the PID path
// goes through one shared 32x24 multiplier used six times in sequence and
// one shared divider that retires four quotient bits a cycle (18 steps for
// the integral term's divide by 1000, 13 steps for the derivative's divide
// by the interval, which is skipped when the interval is zero). A result
// that is not taken holds the block in its output step. A finished result
// sits in the output register until taken, and the next item is accepted
// meanwhile.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle, as the block does not enforce it.

module pid_wall_alignment_unit import pwa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_data,
    pwa_in_if.sink                     i_in,
    pwa_out_if.source                  o_out
);

    localparam logic signed [W_INTEG:0] INTEG_HI = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [W_INTEG:0] INTEG_LO = -INTEG_HI;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INT,
        S_P,
        S_I_LO,
        S_I_HI,
        S_I_DIV,
        S_D1,
        S_D2,
        S_D_DIV,
        S_SUM,
        S_OUT
    } t_state;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [W_MUL_A-1:0] mul_a;
    logic [W_MUL_B-1:0] mul_b;
    logic [W_PROD-1:0]  prod;

    t_state                    r_state;
    logic                      r_op;
    logic signed [W_ERR-1:0]   r_e;
    logic [W_DT-1:0]           r_dt;
    logic signed [W_INTEG-1:0] r_integ;
    logic signed [W_PREV-1:0]  r_prev;
    logic [W_TMO-1:0]          r_elapsed;
    t_status                   r_run;
    logic signed [W_ACC-1:0]   r_acc;
    logic [W_PROD-1:0]         r_wide;
    logic                      r_de_neg;
    logic [W_PULSE-1:0]        r_res_pulse;
    t_status                   r_res_status;
    logic                      r_res_zh;
    logic                      r_out_valid;
    logic [W_PULSE-1:0]        r_out_pulse;
    t_status                   r_out_status;
    logic                      r_out_zh;

    pwa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pwa_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // Error from the selected pair, formed at accept
    // ---------------------------------------------------------------
    logic signed [W_ERR-1:0] in_err;
    assign in_err = cfg.sensor_sel
        ? $signed({1'b0, i_in.right_long})  - $signed({1'b0, i_in.left_long})
        : $signed({1'b0, i_in.right_short}) - $signed({1'b0, i_in.left_short});

    logic             e_neg;
    logic [W_ERR-1:0] e_mag;
    assign e_neg = r_e[W_ERR-1];
    assign e_mag = e_neg ? W_ERR'(-r_e) : W_ERR'(r_e);

    // Elapsed time, saturating at the counter's top
    logic [W_TMO:0]   elapsed_sum;
    logic [W_TMO-1:0] elapsed_new;
    assign elapsed_sum = {1'b0, r_elapsed} + (W_TMO+1)'(r_dt);
    assign elapsed_new = elapsed_sum[W_TMO] ? {W_TMO{1'b1}} : elapsed_sum[W_TMO-1:0];

    // Integral update: the product register holds |e| * interval here
    logic signed [W_INTEG:0]   integ_ext;
    logic signed [W_INTEG:0]   integ_delta;
    logic signed [W_INTEG:0]   integ_sum;
    logic signed [W_INTEG-1:0] integ_new;
    assign integ_ext   = {r_integ[W_INTEG-1], r_integ};
    assign integ_delta = $signed({22'b0, prod[W_ERR+W_DT-1:0]});
    assign integ_sum   = e_neg ? integ_ext - integ_delta : integ_ext + integ_delta;
    always_comb begin
        if (integ_sum > INTEG_HI) begin
            integ_new = INTEG_HI[W_INTEG-1:0];
        end else if (integ_sum < INTEG_LO) begin
            integ_new = INTEG_LO[W_INTEG-1:0];
        end else begin
            integ_new = integ_sum[W_INTEG-1:0];
        end
    end

    // Integral magnitude; saturation keeps it within 47 bits
    logic [W_INTEG-1:0] integ_abs;
    assign integ_abs = r_integ[W_INTEG-1] ? W_INTEG'(-r_integ) : W_INTEG'(r_integ);

    // Error change against the previous sample
    logic signed [W_PREV-1:0] de;
    logic [W_ERR-1:0]         de_mag;
    assign de     = W_PREV'(r_e) - r_prev;
    assign de_mag = de[W_PREV-1] ? W_ERR'(-de) : W_ERR'(de);

    // Signed quotient from the divider, for accumulation
    logic signed [W_ACC-1:0] quot_ext;
    assign quot_ext = $signed({3'b0, div_rsp.quot});

    // Turn: magnitude truncated toward zero, shifted by 24, clamped
    logic [W_ACC-1:0]    acc_abs;
    logic [W_ACC-25:0]   turn_full;
    logic [7:0]          turn_mag;
    logic [W_PULSE-1:0]  turn_pulse;
    assign acc_abs    = r_acc[W_ACC-1] ? W_ACC'(-r_acc) : W_ACC'(r_acc);
    assign turn_full  = acc_abs[W_ACC-1:24];
    assign turn_mag   = (|turn_full[W_ACC-25:8]) ? TURN_LIMIT : turn_full[7:0];
    assign turn_pulse = r_acc[W_ACC-1] ? STOP_PULSE - W_PULSE'(turn_mag)
                                       : STOP_PULSE + W_PULSE'(turn_mag);

    // ---------------------------------------------------------------
    // Multiplier operands: each state issues the product used by the next
    // ---------------------------------------------------------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CHECK: begin  // |e| * interval
                mul_a = W_MUL_A'(e_mag);
                mul_b = W_MUL_B'(r_dt);
            end
            S_INT: begin  // Kp * |e|
                mul_a = W_MUL_A'(e_mag);
                mul_b = cfg.gain_prop;
            end
            S_P: begin  // Ki * low word of |integral|
                mul_a = integ_abs[W_MUL_A-1:0];
                mul_b = cfg.gain_integ;
            end
            S_I_LO: begin  // Ki * high part of |integral|
                mul_a = W_MUL_A'(integ_abs[W_INTEG-2:W_MUL_A]);
                mul_b = cfg.gain_integ;
            end
            S_I_DIV: begin  // |de| * 1000
                mul_a = W_MUL_A'(de_mag);
                mul_b = W_MUL_B'(MS_PER_S);
            end
            S_D1: begin  // Kd * (|de| * 1000)
                mul_a = prod[W_MUL_A-1:0];
                mul_b = cfg.gain_deriv;
            end
            default: ;
        endcase
    end

    // Divider requests: integral term by 1000, derivative term by the interval
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = r_dt;
        div_req.steps    = DIV_STEPS_D;
        case (r_state)
            S_I_HI: begin
                div_req.start    = 1'b1;
                div_req.dividend = W_DIVN'(r_wide) + {prod[W_DIVN-W_MUL_A-1:0], 32'b0};
                div_req.divisor  = MS_PER_S;
                div_req.steps    = DIV_STEPS_I;
            end
            S_D2: begin
                div_req.start    = (r_dt != '0);
                div_req.dividend = {prod[W_DIVN-D_ALIGN_SHIFT-1:0], {D_ALIGN_SHIFT{1'b0}}};
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer, run state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_prev      <= '0;
            r_elapsed   <= '0;
            r_run       <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once the consumer takes it; the output step
            // reloads the register itself
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.op;
                        r_e     <= in_err;
                        r_dt    <= i_in.interval_ms;
                        r_state <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    r_res_pulse <= STOP_PULSE;
                    if (!r_op) begin
                        // start a run: clear the history
                        r_integ      <= '0;
                        r_prev       <= '0;
                        r_elapsed    <= '0;
                        r_run        <= ST_RUN;
                        r_res_status <= ST_RUN;
                        r_res_zh     <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (r_run != ST_RUN) begin
                        // sample outside a run: report, hold everything
                        r_res_status <= r_run;
                        r_res_zh     <= 1'b0;
                        r_state      <= S_OUT;
                    end else begin
                        r_elapsed <= elapsed_new;
                        if (elapsed_new >= cfg.timeout_ms) begin
                            r_run        <= ST_TIMEOUT;
                            r_res_status <= ST_TIMEOUT;
                            r_res_zh     <= 1'b0;
                            r_state      <= S_OUT;
                        end else if (e_mag < W_ERR'(cfg.align_tol)) begin
                            r_run        <= ST_ALIGNED;
                            r_res_status <= ST_ALIGNED;
                            r_res_zh     <= 1'b1;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_INT;
                        end
                    end
                end

                S_INT: begin
                    r_integ <= integ_new;
                    r_state <= S_P;
                end

                S_P: begin
                    // proportional term seeds the accumulator
                    r_acc <= e_neg ? -$signed({13'b0, prod[W_GAIN+W_ERR-1:0]})
                                   :  $signed({13'b0, prod[W_GAIN+W_ERR-1:0]});
                    r_state <= S_I_LO;
                end

                S_I_LO: begin
                    r_wide  <= prod;
                    r_state <= S_I_HI;
                end

                S_I_HI: begin
                    r_state <= S_I_DIV;
                end

                S_I_DIV: begin
                    if (div_rsp.done) begin
                        r_acc    <= r_integ[W_INTEG-1] ? r_acc - quot_ext : r_acc + quot_ext;
                        r_de_neg <= de[W_PREV-1];
                        r_state  <= S_D1;
                    end
                end

                S_D1: begin
                    r_state <= S_D2;
                end

                S_D2: begin
                    // zero interval: derivative term is zero
                    r_state <= (r_dt == '0) ? S_SUM : S_D_DIV;
                end

                S_D_DIV: begin
                    if (div_rsp.done) begin
                        r_acc   <= r_de_neg ? r_acc - quot_ext : r_acc + quot_ext;
                        r_state <= S_SUM;
                    end
                end

                S_SUM: begin
                    r_prev       <= W_PREV'(r_e);
                    r_res_pulse  <= turn_pulse;
                    r_res_status <= ST_RUN;
                    r_res_zh     <= 1'b0;
                    r_state      <= S_OUT;
                end

                S_OUT: begin
                    // advance only into a free (or freeing) output register
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_pulse  <= r_res_pulse;
                        r_out_status <= r_res_status;
                        r_out_zh     <= r_res_zh;
                        r_state      <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.left_pulse    = r_out_pulse;
    assign o_out.right_pulse   = r_out_pulse;
    assign o_out.status        = r_out_status;
    assign o_out.zero_heading  = r_out_zh;

endmodule

`default_nettype wire

[src/pwa_cfg.sv]
`default_nettype none

module pwa_cfg import pwa_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_sel <= 1'b0;
            r_cfg.gain_prop  <= RST_GAIN_PROP;
            r_cfg.gain_integ <= RST_GAIN_INTEG;
            r_cfg.gain_deriv <= RST_GAIN_DERIV;
            r_cfg.align_tol  <= RST_ALIGN_TOL;
            r_cfg.timeout_ms <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSOR_SEL: r_cfg.sensor_sel <= i_cfg_data[0];
                CFG_GAIN_PROP:  r_cfg.gain_prop  <= i_cfg_data[W_GAIN-1:0];
                CFG_GAIN_INTEG: r_cfg.gain_integ <= i_cfg_data[W_GAIN-1:0];
                CFG_GAIN_DERIV: r_cfg.gain_deriv <= i_cfg_data[W_GAIN-1:0];
                CFG_ALIGN_TOL:  r_cfg.align_tol  <= i_cfg_data[W_TOL-1:0];
                CFG_TIMEOUT:    r_cfg.timeout_ms <= i_cfg_data[W_TMO-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/pwa_mul.sv]
`default_nettype none

module pwa_mul import pwa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic [W_MUL_A-1:0] i_a,
    input  wire logic [W_MUL_B-1:0] i_b,
    output logic      [W_PROD-1:0]  o_prod
);

    logic [W_PROD-1:0] r_prod;

    // unsigned product, registered
    always_ff @(posedge i_clk) begin
        r_prod <= W_PROD'(i_a) * W_PROD'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[src/pwa_div.sv]
`default_nettype none

module pwa_div import pwa_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [W_DCNT-1:0] r_cnt;
    logic [W_DIVN-1:0] r_num;
    logic [W_DIVD-1:0] r_divisor;
    logic [W_DIVD-1:0] r_rem;
    logic [W_QUOT-1:0] r_q;
    logic              r_big;

    logic [W_DIVN-1:0]            n_num;
    logic [W_DIVD-1:0]            n_rem;
    logic [DIV_BITS_PER_STEP-1:0] n_qbits;

    // radix-16 restoring step: four quotient bits from the top of the dividend
    always_comb begin
        logic [W_DIVD:0]   rem;
        logic [W_DIVN-1:0] num;
        rem     = {1'b0, r_rem};
        num     = r_num;
        n_qbits = '0;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
            rem = {rem[W_DIVD-1:0], num[W_DIVN-1]};
            num = {num[W_DIVN-2:0], 1'b0};
            if (rem >= {1'b0, r_divisor}) begin
                rem = rem - {1'b0, r_divisor};
                n_qbits[DIV_BITS_PER_STEP-1-k] = 1'b1;
            end
        end
        n_num = num;
        n_rem = rem[W_DIVD-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - W_DCNT'(1);
                if (r_cnt == W_DCNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num     <= i_req.dividend;
            r_divisor <= i_req.divisor;
            r_rem     <= '0;
            r_q       <= '0;
            r_big     <= 1'b0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_q   <= {r_q[W_QUOT-1-DIV_BITS_PER_STEP:0], n_qbits};
            // remember any quotient bit pushed past the kept width
            r_big <= r_big | (|r_q[W_QUOT-1:W_QUOT-DIV_BITS_PER_STEP]);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_big || (r_q[W_QUOT-1] && |r_q[W_QUOT-2:0])) ? TERM_CAP : r_q;

endmodule

`default_nettype wire
